>>> design/sorted_list_insert_and_rank_macros.svh
// ----------------------------------------------------------------------------
// sorted list insert and rank: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_AND_RANK_MACROS_SVH
`define SORTED_LIST_INSERT_AND_RANK_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slir assertion failed");

// next-cycle implication, disabled during reset
`define SLIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slir assertion failed");

`endif

>>> design/slir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_pkg
// shared constants, command codes and control structs of the sorted list
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam int CAPACITY        = 64;
    localparam int VALUE_W         = 32;
    localparam int MODE_W          = 2;
    localparam int POS_W           = 7;
    localparam int HEAD_NODE       = 0;
    localparam int TAIL_NODE       = 1;
    localparam int FIRST_DATA_NODE = 2;

    // command codes, the remaining code is a no-op
    localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_QUERY  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(2);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic link1;
        logic link2;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_walk;
        logic walk_end;
        logic is_insert;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> design/slir_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir channel interfaces
// command channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface slir_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [slir_pkg::MODE_W-1:0]       mode;
    logic signed [slir_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slir_res_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [slir_pkg::POS_W-1:0]   position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

>>> design/sorted_list_insert_and_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_and_rank
// sorted ascending linked list with insert, rank query and clear
// ----------------------------------------------------------------------------
// usage
//   i_cmd carries one command per transaction: mode (insert, query, clear)
//   and a signed 32-bit value; o_res returns exactly one transaction per
//   command with status (1 = insert dropped, store full) and position
//   (1-based rank of the first equal value, 0 if absent or not a query)
//   commands are taken one at a time: i_cmd.ready is high only while the
//   sequencer is idle, and a command may be taken while the last result
//   still waits in the output register; an insert walks past the smaller
//   nodes and then links in the new node, a query walks to the first equal
//   value or to the end of the list, and a clear, a no-op or an insert on a
//   full store goes straight to the result hand-off
//   the walk follows one link a cycle through the registered link store read
//   reset (synchronous, active low) empties the list; the stores need no
//   clearing pass, only linked nodes are ever read
//   a stalled o_res holds its transaction; the next result waits in the
//   sequencer until the output register frees up
// ----------------------------------------------------------------------------
module sorted_list_insert_and_rank #(
    parameter int CAPACITY = slir_pkg::CAPACITY
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    slir_cmd_if.sink     i_cmd,
    slir_res_if.source   o_res
);

    // control and status between sequencer and datapath
    slir_pkg::t_cmd  cmd;
    slir_pkg::t_stat stat;

    // sequencer: idle, walk, two relink steps, result hand-off
    slir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // node stores, walk pointers and the output register
    slir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_mode      (i_cmd.mode),
        .i_in_value     (i_cmd.value),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_out_status   (o_res.status),
        .o_out_position (o_res.position)
    );

endmodule
`default_nettype wire

>>> design/slir_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_ctrl
// sequencing state machine: accept, list walk, relink, result hand-off
// ----------------------------------------------------------------------------
module slir_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire slir_pkg::t_stat i_stat,
    output slir_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_LINK1 = 5'b00100,
        S_LINK2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.need_walk ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_stat.is_insert ? S_LINK1 : S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_LINK1: begin
                o_cmd.link1 = 1'b1;
                n_state     = S_LINK2;
            end
            S_LINK2: begin
                o_cmd.link2 = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> design/slir_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_datapath
// node stores, walk pointers, allocation counter and output register
// ----------------------------------------------------------------------------
module slir_datapath #(
    parameter int CAPACITY = slir_pkg::CAPACITY
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire slir_pkg::t_cmd                    i_cmd,
    output slir_pkg::t_stat                        o_stat,
    input  wire logic [slir_pkg::MODE_W-1:0]       i_in_mode,
    input  wire logic signed [slir_pkg::VALUE_W-1:0] i_in_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_status,
    output logic [slir_pkg::POS_W-1:0]             o_out_position
);

    localparam int NODES = CAPACITY + 2;
    localparam int NW    = $clog2(NODES);
    localparam int FW    = $clog2(NODES + 1);
    localparam int PW    = slir_pkg::POS_W;
    localparam int VW    = slir_pkg::VALUE_W;

    localparam logic [NW-1:0] HEAD = NW'(slir_pkg::HEAD_NODE);
    localparam logic [NW-1:0] TAIL = NW'(slir_pkg::TAIL_NODE);

    // node stores, sentinel entries unused (head link lives in a register)
    logic signed [VW-1:0] r_val_mem  [NODES];
    logic [NW-1:0]        r_next_mem [NODES];

    logic signed [VW-1:0] r_rd_val;
    logic [NW-1:0]        r_rd_next;

    logic [slir_pkg::MODE_W-1:0] r_mode;
    logic signed [VW-1:0]        r_value;
    logic [NW-1:0]               r_head_next;
    logic [FW-1:0]               r_free;
    logic [NW-1:0]               r_cur;
    logic [NW-1:0]               r_pred;
    logic [PW-1:0]               r_count;
    logic                        r_status;
    logic [PW-1:0]               r_pos;
    logic                        r_out_valid;
    logic                        r_out_status;
    logic [PW-1:0]               r_out_pos;

    logic          full;
    logic          is_insert;
    logic          at_tail;
    logic [NW-1:0] fresh;
    logic [NW-1:0] rd_addr;
    logic          nx_we;
    logic [NW-1:0] nx_addr;
    logic [NW-1:0] nx_data;

    assign full      = (r_free >= FW'(NODES));
    assign is_insert = (r_mode == slir_pkg::MODE_INSERT);
    assign at_tail   = (r_cur == TAIL);
    assign fresh     = r_free[NW-1:0];

    // read the first node on acceptance, then follow the fetched link
    assign rd_addr = i_cmd.load ? r_head_next : r_rd_next;

    // one write port on the link store: new node first, predecessor second
    assign nx_we   = i_cmd.link1 || (i_cmd.link2 && (r_pred != HEAD));
    assign nx_addr = i_cmd.link1 ? fresh : r_pred;
    assign nx_data = i_cmd.link1 ? r_cur : fresh;

    always_comb begin
        o_stat.need_walk = ((i_in_mode == slir_pkg::MODE_INSERT) && !full)
                        || (i_in_mode == slir_pkg::MODE_QUERY);
        o_stat.is_insert = is_insert;
        o_stat.out_free  = !r_out_valid || i_out_ready;
        if (is_insert) begin
            o_stat.walk_end = at_tail || (r_rd_val >= r_value);
        end else begin
            o_stat.walk_end = at_tail || (r_rd_val == r_value);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_val  <= r_val_mem[rd_addr];
        r_rd_next <= r_next_mem[rd_addr];
        if (i_cmd.link1) begin
            r_val_mem[fresh] <= r_value;
        end
        if (nx_we) begin
            r_next_mem[nx_addr] <= nx_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_mode;
            r_value  <= i_in_value;
            r_cur    <= r_head_next;
            r_pred   <= HEAD;
            r_count  <= PW'(1);
            r_status <= (i_in_mode == slir_pkg::MODE_INSERT) && full;
            r_pos    <= '0;
        end
        if (i_cmd.step) begin
            r_pred  <= r_cur;
            r_cur   <= r_rd_next;
            r_count <= r_count + PW'(1);
        end
        if (i_cmd.finish && !is_insert && !at_tail) begin
            r_pos <= r_count;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_next <= TAIL;
            r_free      <= FW'(slir_pkg::FIRST_DATA_NODE);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (i_in_mode == slir_pkg::MODE_CLEAR)) begin
                r_head_next <= TAIL;
                r_free      <= FW'(slir_pkg::FIRST_DATA_NODE);
            end
            if (i_cmd.link1 && (r_pred == HEAD)) begin
                r_head_next <= fresh;
            end
            if (i_cmd.link2) begin
                r_free <= r_free + FW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_position = r_out_pos;

endmodule
`default_nettype wire

>>> design/slir_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_checker
// port-level assertions on the sorted list, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_list_insert_and_rank_macros.svh"

module slir_checker #(
    parameter int CAPACITY = slir_pkg::CAPACITY
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cmd_valid,
    input wire logic                         i_cmd_ready,
    input wire logic                         i_res_valid,
    input wire logic                         i_res_ready,
    input wire logic                         i_res_status,
    input wire logic [slir_pkg::POS_W-1:0]   i_res_position
);

    // a dropped insert never reports a rank
    `SLIR_ASSERT_IMP(a_drop_no_pos, i_clk, i_rst_n, i_res_valid && i_res_status, i_res_position == '0)

    // rank never exceeds the store capacity
    `SLIR_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, i_res_valid, i_res_position <= slir_pkg::POS_W'(CAPACITY))

    // one command at a time: no acceptance right after an acceptance
    `SLIR_ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready)

    // a stalled result holds
    `SLIR_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_status) && $stable(i_res_position))

endmodule

bind sorted_list_insert_and_rank slir_checker #(
    .CAPACITY (CAPACITY)
) u_slir_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cmd_valid    (i_cmd.valid),
    .i_cmd_ready    (i_cmd.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_status   (o_res.status),
    .i_res_position (o_res.position)
);
`default_nettype wire

>>> tb/sv/slir_list_checker.sv
// ----------------------------------------------------------------------------
// slir_list_checker
// watches the command and result channels of the sorted list, keeps its own
// copy of the list, works out the answer to each command and compares
// ----------------------------------------------------------------------------
module slir_list_checker
    import slir_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slir_cmd_if       i_cmd,
    slir_res_if       i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_drops,
    output int        o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES      = CAPACITY + 2;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] position;
    } t_answer;

    // shadow list: node values, forward and backward links, allocation pointer
    logic signed [VALUE_W-1:0] node_value [NODES];
    int                        fwd_link   [NODES];
    int                        back_link  [NODES];
    int                        alloc_node;

    t_answer awaited_answers [$];
    int      mismatches;
    int      drops;
    int      hits;
    int      answers_seen;

    function automatic void empty_the_list();
        fwd_link[HEAD_NODE]  = TAIL_NODE;
        back_link[TAIL_NODE] = HEAD_NODE;
        alloc_node           = FIRST_DATA_NODE;
    endfunction

    // applies one command to the shadow list and returns its answer
    function automatic t_answer apply_to_list(input logic [MODE_W-1:0] mode,
                                              input logic signed [VALUE_W-1:0] val);
        t_answer ans;
        int      node;
        int      slot;
        int      count;
        int      pred_node;
        ans  = '0;
        node = fwd_link[HEAD_NODE];
        if (mode == MODE_INSERT) begin
            if (alloc_node >= NODES) begin
                ans.status = 1'b1;
            end else begin
                // first node not below the new value, new node goes ahead of it
                slot  = TAIL_NODE;
                count = 0;
                while (node != TAIL_NODE && node < NODES && count < CAPACITY) begin
                    if (node_value[node] >= val) begin
                        slot = node;
                        break;
                    end
                    node = fwd_link[node];
                    count++;
                end
                pred_node = back_link[slot];
                if (pred_node >= NODES)
                    pred_node = HEAD_NODE;
                node_value[alloc_node] = val;
                fwd_link[alloc_node]   = slot;
                back_link[alloc_node]  = pred_node;
                fwd_link[pred_node]    = alloc_node;
                back_link[slot]        = alloc_node;
                alloc_node++;
            end
        end else if (mode == MODE_QUERY) begin
            count = 1;
            while (node != TAIL_NODE && node < NODES && count <= CAPACITY) begin
                if (node_value[node] == val) begin
                    ans.position = POS_W'(count);
                    break;
                end
                node = fwd_link[node];
                count++;
            end
        end else if (mode == MODE_CLEAR) begin
            empty_the_list();
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            empty_the_list();
            awaited_answers.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] result %0d with no command waiting: %s %0d %0d",
                                 $realtime, answers_seen, "status/position",
                                 i_res.status, i_res.position);
                end else begin
                    want = awaited_answers.pop_front();
                    if (i_res.status !== want.status || i_res.position !== want.position) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("[%0t] result %0d: status exp %0d got %0d, %s %0d got %0d",
                                     $realtime, answers_seen, want.status, i_res.status,
                                     "position exp", want.position, i_res.position);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                want = apply_to_list(i_cmd.mode, i_cmd.value);
                awaited_answers = {awaited_answers, want};
                if (want.status)
                    drops++;
                if (i_cmd.mode == MODE_QUERY && want.position != '0)
                    hits++;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_answers.size();
        o_drops      <= drops;
        o_hits       <= hits;
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression of the sorted list: directed commands at the value extremes,
// then random episodes of inserts, queries and clears, some filling the
// store past capacity, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slir_pkg::*;

    // unused command code, the block answers it without touching the list
    localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam int ITEM_TARGET   = 500;
    localparam int STEADY_FIRST  = 150;  // no idling on either side in this stretch
    localparam int STEADY_LAST   = 230;
    localparam int HOLD_AT_ITEM  = 320;  // receiver backs off here
    localparam int HOLD_CYCLES   = 400;
    localparam int HISTORY_DEPTH = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = CAPACITY + 16;  // longer than the longest walk

    logic i_clk = 1'b0;
    logic i_rst_n;

    slir_cmd_if cmd_ch ();
    slir_res_if res_ch ();

    int  fail_count;
    int  pending;
    int  drops;
    int  hits;

    bit  steady;
    bit  hold_req;
    int  items_sent;
    int  n_insert;
    int  n_query;
    int  n_clear;
    int  n_unused;

    // recently inserted values, so that queries hit often
    logic signed [VALUE_W-1:0] history [$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sorted_list_insert_and_rank u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    slir_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_drops      (drops),
        .o_hits       (hits)
    );

    // small values collide a lot, extremes probe the signed order, the rest
    // exercises every bit
    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_W'($urandom_range(0, 8)) - VALUE_W'(4);
            4: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return VAL_MIN + 1;
                    default: return VAL_MAX - 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // half the lookups reuse a recent insert, the rest are mostly misses
    function automatic logic signed [VALUE_W-1:0] draw_probe();
        if (history.size() > 0 && $urandom_range(0, 1) == 1)
            return history[$urandom_range(0, history.size() - 1)];
        return draw_value();
    endfunction

    // offers one command, with a random idle gap first, and returns once
    // the transaction has gone through
    task automatic issue(input logic [MODE_W-1:0] mode,
                         input logic signed [VALUE_W-1:0] val);
        while (!steady && $urandom_range(0, 99) < 33) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= mode;
        cmd_ch.value <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        case (mode)
            MODE_INSERT: begin
                n_insert++;
                history = {history, val};
                if (history.size() > HISTORY_DEPTH)
                    void'(history.pop_front());
            end
            MODE_QUERY: n_query++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
        // the unused code does nothing, so it does not count towards the total
        if (mode != MODE_UNUSED)
            items_sent++;
        if (items_sent == HOLD_AT_ITEM)
            hold_req <= 1'b1;
        steady <= (items_sent >= STEADY_FIRST && items_sent < STEADY_LAST);
    endtask

    // result side: random back-pressure, and one long hold-off while the
    // sender keeps offering, so that both the output register and the
    // sequencer fill up and the command channel stalls
    initial begin : result_sink
        int k;
        bit hold_done;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin : stimulus
        int episode;
        int n;
        int k;
        int pick;
        int waited;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode  <= MODE_INSERT;
        cmd_ch.value <= '0;
        i_rst_n      <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lookup on an empty list, unused code
        issue(MODE_QUERY, 5);
        issue(MODE_UNUSED, -32'sd1);
        // extremes of the signed range, duplicates go ahead of older equals
        issue(MODE_INSERT, 0);
        issue(MODE_INSERT, VAL_MAX);
        issue(MODE_INSERT, VAL_MIN);
        issue(MODE_INSERT, -32'sd1);
        issue(MODE_INSERT, 0);
        issue(MODE_INSERT, VAL_MAX);
        issue(MODE_QUERY, VAL_MIN);
        issue(MODE_QUERY, 0);
        issue(MODE_QUERY, VAL_MAX);
        issue(MODE_QUERY, -32'sd1);
        issue(MODE_QUERY, 1);
        issue(MODE_QUERY, VAL_MIN + 1);
        // after a clear the old values sit in the store but are unreachable
        issue(MODE_CLEAR, 0);
        issue(MODE_QUERY, 0);
        issue(MODE_QUERY, VAL_MAX);
        // alternating bit patterns
        issue(MODE_INSERT, 32'sh5555_5555);
        issue(MODE_INSERT, 32'shAAAA_AAAA);
        issue(MODE_QUERY, 32'shAAAA_AAAA);
        issue(MODE_QUERY, 32'sh5555_5555);
        issue(MODE_UNUSED, 0);
        issue(MODE_CLEAR, -32'sd1);

        // random episodes, each opening with a clear; the first one and
        // about a quarter of the rest run the store past full
        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            issue(MODE_CLEAR, draw_value());
            if (episode == 0 || $urandom_range(0, 3) == 0) begin
                n = CAPACITY + $urandom_range(1, 8);
                k = 0;
                while (k < n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        issue(MODE_INSERT, draw_value());
                        k++;
                    end else if (pick < 97) begin
                        issue(MODE_QUERY, draw_probe());
                    end else begin
                        issue(MODE_UNUSED, draw_value());
                    end
                end
            end else begin
                n = $urandom_range(4, 40);
                for (k = 0; k < n; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        issue(MODE_INSERT, draw_value());
                    else if (pick < 90)
                        issue(MODE_QUERY, draw_probe());
                    else if (pick < 95)
                        issue(MODE_CLEAR, draw_value());   // clear in mid-sequence
                    else
                        issue(MODE_UNUSED, draw_value());
                end
            end
            episode++;
        end
        cmd_ch.valid <= 1'b0;

        // drain: every answer in, then room for a late stray transaction
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d commands in %0d episodes: %0d inserts, %0d queries,",
                 items_sent + n_unused, episode, n_insert, n_query);
        $display("%0d clears and %0d unused codes; %0d inserts dropped on a full store, %s",
                 n_clear, n_unused, drops, $sformatf("%0d queries found their value", hits));
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_list_insert_and_rank regression: pass");
        end else begin
            $display("sorted_list_insert_and_rank regression: fail");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("sorted_list_insert_and_rank regression: fail");
        $finish;
    end

endmodule
